/* hw/rtl/pdc_pkg.sv */
// ----------------------------------------------------------------------------
// pdc_pkg
// shared constants, configuration type and rgb565 helpers for the palette
// downscale compositor
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam int SOURCE_WIDTH_DEF    = 320;
	localparam int SOURCE_HEIGHT_DEF   = 200;
	localparam int PALETTE_ENTRIES_DEF = 256;

	localparam int COLOR_W = 16;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	// register indexes
	localparam logic [2:0] REG_SCALE_MODE     = 3'd0;
	localparam logic [2:0] REG_AVERAGE_ENABLE = 3'd1;
	localparam logic [2:0] REG_BLUE_FIRST     = 3'd2;
	localparam logic [2:0] REG_CROP_LEFT      = 3'd3;
	localparam logic [2:0] REG_CROP_WIDTH     = 3'd4;
	localparam logic [2:0] REG_CROP_ROWS      = 3'd5;

	// position mod 4 that is dropped in scale mode
	localparam logic [1:0] SKIP_AVG  = 2'd0;
	localparam logic [1:0] SKIP_DROP = 2'd3;

	localparam logic [COLOR_W-1:0] MIX_MASK = 16'hF7DE;

	typedef struct packed {
		logic       scale_mode;
		logic       average_enable;
		logic       blue_first;
		logic [8:0] crop_left;
		logic [8:0] crop_width;
		logic [7:0] crop_rows;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
	} mark_t;

	function automatic logic [COLOR_W-1:0] mix565(input logic [COLOR_W-1:0] x,
			input logic [COLOR_W-1:0] y);
		mix565 = (((x ^ y) & MIX_MASK) >> 1) + (x & y);
	endfunction

	function automatic logic [COLOR_W-1:0] pack565(input logic first,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = first ? b : r;
		lo = first ? r : b;
		pack565 = {hi[7:3], g[7:2], lo[7:3]};
	endfunction

endpackage

/* hw/rtl/pdc_ram.sv */
// ----------------------------------------------------------------------------
// pdc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/pdc_cfg.sv */
// ----------------------------------------------------------------------------
// pdc_cfg
// apb register file holding mode, palette order and crop window settings
// ----------------------------------------------------------------------------
module pdc_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [pdc_pkg::APB_AW-1:0] paddr,
	input  logic [pdc_pkg::APB_DW-1:0] pwdata,
	output logic [pdc_pkg::APB_DW-1:0] prdata,
	output logic                  pready,
	output pdc_pkg::cfg_t         cfg
);
	import pdc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_mode     <= 1'b0;
			cfg_q.average_enable <= 1'b1;
			cfg_q.blue_first     <= 1'b1;
			cfg_q.crop_left      <= 9'd40;
			cfg_q.crop_width     <= 9'd240;
			cfg_q.crop_rows      <= 8'd200;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SCALE_MODE:     cfg_q.scale_mode     <= pwdata[0];
				REG_AVERAGE_ENABLE: cfg_q.average_enable <= pwdata[0];
				REG_BLUE_FIRST:     cfg_q.blue_first     <= pwdata[0];
				REG_CROP_LEFT:      cfg_q.crop_left      <= pwdata[8:0];
				REG_CROP_WIDTH:     cfg_q.crop_width     <= pwdata[8:0];
				REG_CROP_ROWS:      cfg_q.crop_rows      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SCALE_MODE:     prdata = APB_DW'(cfg_q.scale_mode);
			REG_AVERAGE_ENABLE: prdata = APB_DW'(cfg_q.average_enable);
			REG_BLUE_FIRST:     prdata = APB_DW'(cfg_q.blue_first);
			REG_CROP_LEFT:      prdata = APB_DW'(cfg_q.crop_left);
			REG_CROP_WIDTH:     prdata = APB_DW'(cfg_q.crop_width);
			REG_CROP_ROWS:      prdata = APB_DW'(cfg_q.crop_rows);
			default:            prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/pdc_raster.sv */
// ----------------------------------------------------------------------------
// pdc_raster
// raster position counters and per-pixel emit, row end and frame end marks
// ----------------------------------------------------------------------------
module pdc_raster #(
	parameter int SOURCE_WIDTH  = pdc_pkg::SOURCE_WIDTH_DEF,
	parameter int SOURCE_HEIGHT = pdc_pkg::SOURCE_HEIGHT_DEF,
	parameter int CW = $clog2(SOURCE_WIDTH),
	parameter int RW = $clog2(SOURCE_HEIGHT)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pdc_pkg::cfg_t  cfg,
	input  logic           step,
	input  logic           frame_start,
	output logic [CW-1:0]  col,
	output pdc_pkg::mark_t mark
);
	import pdc_pkg::*;

	localparam int XW = ((CW > 9) ? CW : 9) + 1;
	localparam int YW = ((RW > 8) ? RW : 8) + 1;
	localparam int LAST_COL_AVG  = (((SOURCE_WIDTH - 1) % 4) == 0) ?
		SOURCE_WIDTH - 2 : SOURCE_WIDTH - 1;
	localparam int LAST_COL_DROP = (((SOURCE_WIDTH - 1) % 4) == 3) ?
		SOURCE_WIDTH - 2 : SOURCE_WIDTH - 1;
	localparam int LAST_ROW_AVG  = (((SOURCE_HEIGHT - 1) % 4) == 0) ?
		SOURCE_HEIGHT - 2 : SOURCE_HEIGHT - 1;
	localparam int LAST_ROW_DROP = (((SOURCE_HEIGHT - 1) % 4) == 3) ?
		SOURCE_HEIGHT - 2 : SOURCE_HEIGHT - 1;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;
	logic          col_last;
	logic          row_last;

	logic [1:0]    skip;
	logic          keep;
	logic          scale_rend;
	logic          scale_fend;

	logic [XW-1:0] col_x;
	logic [XW-1:0] cend_raw;
	logic [XW-1:0] cend;
	logic [YW-1:0] row_x;
	logic [YW-1:0] rend_row;
	logic          crop_in;
	logic          crop_rend;

	assign col_cur  = frame_start ? '0 : col_q;
	assign row_cur  = frame_start ? '0 : row_q;
	assign col_last = (col_cur == CW'(SOURCE_WIDTH - 1));
	assign row_last = (row_cur == RW'(SOURCE_HEIGHT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_cur + RW'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// three-quarter scale
	assign skip = cfg.average_enable ? SKIP_AVG : SKIP_DROP;
	assign keep = (col_cur[1:0] != skip) && (row_cur[1:0] != skip);
	assign scale_rend = cfg.average_enable ? (col_cur == CW'(LAST_COL_AVG)) :
		(col_cur == CW'(LAST_COL_DROP));
	assign scale_fend = scale_rend && (cfg.average_enable ?
		(row_cur == RW'(LAST_ROW_AVG)) : (row_cur == RW'(LAST_ROW_DROP)));

	// crop window clipped to the frame
	assign col_x    = XW'(col_cur);
	assign row_x    = YW'(row_cur);
	assign cend_raw = XW'(cfg.crop_left) + XW'(cfg.crop_width);
	assign cend     = (cend_raw > XW'(SOURCE_WIDTH)) ? XW'(SOURCE_WIDTH) : cend_raw;
	assign rend_row = (YW'(cfg.crop_rows) > YW'(SOURCE_HEIGHT)) ?
		YW'(SOURCE_HEIGHT) : YW'(cfg.crop_rows);
	assign crop_in  = (col_x >= XW'(cfg.crop_left)) && (col_x < cend) && (row_x < rend_row);
	assign crop_rend = (col_x + XW'(1) == cend);

	always_comb begin
		if (cfg.scale_mode) begin
			mark.emit      = keep;
			mark.row_end   = keep && scale_rend;
			mark.frame_end = keep && scale_fend;
		end else begin
			mark.emit      = crop_in;
			mark.row_end   = crop_in && crop_rend;
			mark.frame_end = crop_in && crop_rend && (row_x + YW'(1) == rend_row);
		end
	end

	assign col = col_cur;

endmodule

/* hw/rtl/palette_downscale_compositor.sv */
// ----------------------------------------------------------------------------
// palette_downscale_compositor
// palette lookup of indexed source pixels with crop or three-quarter downscale
// ----------------------------------------------------------------------------
// Takes one word per clock while the output side keeps ready high: a source
// pixel index or a palette write. When a pixel is accepted, its palette
// color and the line buffer entry above it are read from the two rams at
// that edge into the read stage, and the result word of an emitted pixel
// then moves into the output register. The line buffer
// write of a pixel happens as it leaves the read stage; a following pixel at
// the same column takes the value by forwarding. Entries of either ram not yet
// written since reset read as zero (valid bits on the palette, a fill count on
// the line buffer), so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module palette_downscale_compositor #(
	parameter int SOURCE_WIDTH    = pdc_pkg::SOURCE_WIDTH_DEF,
	parameter int SOURCE_HEIGHT   = pdc_pkg::SOURCE_HEIGHT_DEF,
	parameter int PALETTE_ENTRIES = pdc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pdc_pkg::APB_AW-1:0]  paddr,
	input  logic [pdc_pkg::APB_DW-1:0]  pwdata,
	output logic [pdc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        src_valid,
	output logic                        src_ready,
	input  logic                        action,
	input  logic                        frame_start,
	input  logic [7:0]                  pixel_index,
	input  logic [7:0]                  palette_slot,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	output logic                        dst_valid,
	input  logic                        dst_ready,
	output logic [pdc_pkg::COLOR_W-1:0] pixel_color,
	output logic                        row_end,
	output logic                        frame_end
);
	import pdc_pkg::*;

	localparam int CW  = $clog2(SOURCE_WIDTH);
	localparam int RW  = $clog2(SOURCE_HEIGHT);
	localparam int PAW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	cfg_t                cfg;
	mark_t               mark;
	logic [CW-1:0]       col;

	logic                src_acc;
	logic                pix_acc;
	logic                pal_wr;
	logic [PAW-1:0]      pal_waddr;
	logic [COLOR_W-1:0]  pal_wdata;
	logic [COLOR_W-1:0]  pal_rdata;
	logic [COLOR_W-1:0]  lb_rdata;
	logic [PALETTE_ENTRIES-1:0] pal_valid_q;
	logic [CW:0]         lb_fill_q;

	logic                s1_valid_q;
	mark_t               mark_s1;
	logic [CW-1:0]       col_s1;
	logic                pal_hit_s1;
	logic                lb_hit_s1;
	logic                fwd_s1;
	logic [COLOR_W-1:0]  fwd_data_s1;
	logic                s1_go;

	logic [COLOR_W-1:0]  cur;
	logic [COLOR_W-1:0]  up;
	logic [COLOR_W-1:0]  color;
	logic [COLOR_W-1:0]  left_q;
	logic [COLOR_W-1:0]  upper_left_q;

	logic                out_free;
	logic                dst_valid_q;
	logic [COLOR_W-1:0]  color_q;
	logic                row_end_q;
	logic                frame_end_q;

	pdc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdc_raster #(
		.SOURCE_WIDTH  (SOURCE_WIDTH),
		.SOURCE_HEIGHT (SOURCE_HEIGHT),
		.CW            (CW),
		.RW            (RW)
	) u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (pix_acc),
		.frame_start (frame_start),
		.col         (col),
		.mark        (mark)
	);

	// handshake
	assign out_free  = !dst_valid_q || dst_ready;
	assign s1_go     = s1_valid_q && (!mark_s1.emit || out_free);
	assign src_ready = !s1_valid_q || s1_go;
	assign src_acc   = src_valid && src_ready;
	assign pix_acc   = src_acc && !action;

	// palette
	assign pal_wr    = src_acc && action && ({1'b0, palette_slot} < 9'(PALETTE_ENTRIES));
	assign pal_waddr = palette_slot[PAW-1:0];
	assign pal_wdata = pack565(cfg.blue_first, red, green, blue);

	pdc_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES),
		.AW    (PAW)
	) u_palette (
		.clk   (clk),
		.we    (pal_wr),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (pix_acc),
		.raddr (pixel_index[PAW-1:0]),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (pal_wr) begin
			pal_valid_q[pal_waddr] <= 1'b1;
		end
	end

	// line buffer, written as a pixel leaves the read stage
	pdc_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (SOURCE_WIDTH),
		.AW    (CW)
	) u_line_buffer (
		.clk   (clk),
		.we    (s1_go),
		.waddr (col_s1),
		.wdata (cur),
		.re    (pix_acc),
		.raddr (col),
		.rdata (lb_rdata)
	);

	// written columns always form a prefix from column zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_fill_q <= '0;
		end else if (s1_go && ({1'b0, col_s1} == lb_fill_q)) begin
			lb_fill_q <= lb_fill_q + (CW+1)'(1);
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			mark_s1     <= mark;
			col_s1      <= col;
			pal_hit_s1  <= ({1'b0, pixel_index} < 9'(PALETTE_ENTRIES)) &&
				pal_valid_q[pixel_index[PAW-1:0]];
			lb_hit_s1   <= ({1'b0, col} < lb_fill_q);
			fwd_s1      <= s1_go && (col_s1 == col);
			fwd_data_s1 <= cur;
		end
	end

	assign cur = pal_hit_s1 ? pal_rdata : '0;
	assign up  = fwd_s1 ? fwd_data_s1 : (lb_hit_s1 ? lb_rdata : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (s1_go) begin
			left_q       <= cur;
			upper_left_q <= up;
		end
	end

	assign color = (cfg.scale_mode && cfg.average_enable) ?
		mix565(mix565(upper_left_q, up), mix565(left_q, cur)) : cur;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (s1_go && mark_s1.emit) begin
			dst_valid_q <= 1'b1;
		end else if (dst_ready) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && mark_s1.emit) begin
			color_q     <= color;
			row_end_q   <= mark_s1.row_end;
			frame_end_q <= mark_s1.frame_end;
		end
	end

	assign dst_valid   = dst_valid_q;
	assign pixel_color = color_q;
	assign row_end     = row_end_q;
	assign frame_end   = frame_end_q;

endmodule

/* dv/pdc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdc_checker
// Watches the register port and both word channels of the palette downscale
// compositor. It keeps its own palette, line buffer, neighbor colors, raster
// position and settings, works out the color word that each accepted source
// word should produce, and matches every accepted output word against the
// oldest expected one. It hands back the mismatch count and the number of
// pixel words still expected.
// ----------------------------------------------------------------------------
module pdc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [pdc_pkg::APB_AW-1:0]  paddr,
	input  logic [pdc_pkg::APB_DW-1:0]  pwdata,
	input  logic                        src_valid,
	input  logic                        src_ready,
	input  logic                        action,
	input  logic                        frame_start,
	input  logic [7:0]                  pixel_index,
	input  logic [7:0]                  palette_slot,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic                        dst_valid,
	input  logic                        dst_ready,
	input  logic [pdc_pkg::COLOR_W-1:0] pixel_color,
	input  logic                        row_end,
	input  logic                        frame_end,
	output int                          mismatch_count,
	output int                          pixels_outstanding
);
	import pdc_pkg::*;

	localparam int WIDTH       = SOURCE_WIDTH_DEF;
	localparam int HEIGHT      = SOURCE_HEIGHT_DEF;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               row_last;
		logic               frame_last;
	} pixel_word_t;

	logic [COLOR_W-1:0] palette [PALETTE_ENTRIES_DEF];
	logic [COLOR_W-1:0] line_mem [WIDTH];
	logic [COLOR_W-1:0] left_color;
	logic [COLOR_W-1:0] upper_left_color;
	logic [8:0]         col_pos;
	logic [7:0]         row_pos;
	cfg_t               settings;
	pixel_word_t        expected_pixels [$];
	pixel_word_t        oldest;

	function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] x,
			input logic [COLOR_W-1:0] y);
		return (((x ^ y) & MIX_MASK) >> 1) + (x & y);
	endfunction

	// last position below n that is not dropped
	function automatic int unsigned final_kept(input int unsigned n, input logic [1:0] skip);
		int unsigned p;
		p = n - 1;
		if ((p % 4) == skip)
			p = p - 1;
		return p;
	endfunction

	function automatic void note_mismatch(input string field, input logic [COLOR_W-1:0] want,
			input logic [COLOR_W-1:0] got);
		mismatch_count++;
		$error("%s expected %0h got %0h", field, want, got);
	endfunction

	task automatic apply_register_write();
		case (paddr[4:2])
			REG_SCALE_MODE:     settings.scale_mode     = pwdata[0];
			REG_AVERAGE_ENABLE: settings.average_enable = pwdata[0];
			REG_BLUE_FIRST:     settings.blue_first     = pwdata[0];
			REG_CROP_LEFT:      settings.crop_left      = pwdata[8:0];
			REG_CROP_WIDTH:     settings.crop_width     = pwdata[8:0];
			REG_CROP_ROWS:      settings.crop_rows      = pwdata[7:0];
			default: ;
		endcase
	endtask

	task automatic predict_source_word();
		logic [COLOR_W-1:0] cur;
		logic [COLOR_W-1:0] up;
		logic [7:0]         hi;
		logic [7:0]         lo;
		logic [1:0]         skip;
		int unsigned        col_stop;
		int unsigned        row_stop;
		pixel_word_t        word;
		bit                 emit;
		if (action) begin
			hi = settings.blue_first ? blue : red;
			lo = settings.blue_first ? red : blue;
			palette[palette_slot] = {hi[7:3], green[7:2], lo[7:3]};
			return;
		end
		if (frame_start) begin
			col_pos = '0;
			row_pos = '0;
		end
		cur  = palette[pixel_index];
		up   = line_mem[col_pos];
		emit = 1'b0;
		word = '0;
		if (settings.scale_mode) begin
			skip = settings.average_enable ? SKIP_AVG : SKIP_DROP;
			if (col_pos[1:0] != skip && row_pos[1:0] != skip) begin
				emit = 1'b1;
				word.color = settings.average_enable ?
					blend(blend(upper_left_color, up), blend(left_color, cur)) : cur;
				word.row_last   = (col_pos == final_kept(WIDTH, skip));
				word.frame_last = word.row_last && (row_pos == final_kept(HEIGHT, skip));
			end
		end else begin
			col_stop = settings.crop_left + settings.crop_width;
			row_stop = settings.crop_rows;
			if (col_stop > WIDTH)
				col_stop = WIDTH;
			if (row_stop > HEIGHT)
				row_stop = HEIGHT;
			if (col_pos >= settings.crop_left && col_pos < col_stop && row_pos < row_stop) begin
				emit = 1'b1;
				word.color      = cur;
				word.row_last   = (col_pos + 1 == col_stop);
				word.frame_last = word.row_last && (row_pos + 1 == row_stop);
			end
		end
		upper_left_color  = up;
		left_color        = cur;
		line_mem[col_pos] = cur;
		if (col_pos == WIDTH - 1) begin
			col_pos = '0;
			row_pos = (row_pos == HEIGHT - 1) ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		if (emit)
			expected_pixels.push_back(word);
	endtask

	task automatic check_pixel_word();
		if (expected_pixels.size() == 0) begin
			note_mismatch("pixel_color (no word expected)", '0, pixel_color);
			return;
		end
		oldest = expected_pixels.pop_front();
		if (pixel_color !== oldest.color)
			note_mismatch("pixel_color", oldest.color, pixel_color);
		if (row_end !== oldest.row_last)
			note_mismatch("row_end", COLOR_W'(oldest.row_last), COLOR_W'(row_end));
		if (frame_end !== oldest.frame_last)
			note_mismatch("frame_end", COLOR_W'(oldest.frame_last), COLOR_W'(frame_end));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_ENTRIES_DEF; i++)
				palette[i] = '0;
			for (int i = 0; i < WIDTH; i++)
				line_mem[i] = '0;
			left_color       = '0;
			upper_left_color = '0;
			col_pos          = '0;
			row_pos          = '0;
			settings.scale_mode     = 1'b0;
			settings.average_enable = 1'b1;
			settings.blue_first     = 1'b1;
			settings.crop_left      = 9'd40;
			settings.crop_width     = 9'd240;
			settings.crop_rows      = 8'd200;
			expected_pixels.delete();
			mismatch_count     = 0;
			pixels_outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				apply_register_write();
			if (dst_valid && dst_ready)
				check_pixel_word();
			if (src_valid && src_ready)
				predict_source_word();
			pixels_outstanding = expected_pixels.size();
		end
	end

endmodule

/* dv/tb_palette_downscale_compositor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_downscale_compositor
// Drives palette loads and indexed source pixels into the compositor through
// crop, averaging and drop settings, with random gaps on the source side and
// random stalls plus one long hold-off on the output side. A short directed
// run comes first, then random pixel runs from frame starts with stray
// restarts, where short crop windows reach the row and frame marks. The
// checker beside the block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_palette_downscale_compositor;
	import pdc_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES   = 6;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SEGMENT_WORDS   = 250;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [APB_AW-1:0]   paddr        = '0;
	logic [APB_DW-1:0]   pwdata       = '0;
	logic                src_valid    = 1'b0;
	logic                action       = 1'b0;
	logic                frame_start  = 1'b0;
	logic [7:0]          pixel_index  = '0;
	logic [7:0]          palette_slot = '0;
	logic [7:0]          red          = '0;
	logic [7:0]          green        = '0;
	logic [7:0]          blue         = '0;
	logic                dst_ready    = 1'b0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                src_ready;
	logic                dst_valid;
	logic [COLOR_W-1:0]  pixel_color;
	logic                row_end;
	logic                frame_end;

	int mismatch_count;
	int pixels_outstanding;
	int src_idle_pct  = 0;
	int dst_idle_pct  = 0;
	int hold_requests = 0;
	int holds_done    = 0;
	int cycle_count   = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	palette_downscale_compositor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.action       (action),
		.frame_start  (frame_start),
		.pixel_index  (pixel_index),
		.palette_slot (palette_slot),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.dst_valid    (dst_valid),
		.dst_ready    (dst_ready),
		.pixel_color  (pixel_color),
		.row_end      (row_end),
		.frame_end    (frame_end)
	);

	pdc_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.pready             (pready),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.src_valid          (src_valid),
		.src_ready          (src_ready),
		.action             (action),
		.frame_start        (frame_start),
		.pixel_index        (pixel_index),
		.palette_slot       (palette_slot),
		.red                (red),
		.green              (green),
		.blue               (blue),
		.dst_valid          (dst_valid),
		.dst_ready          (dst_ready),
		.pixel_color        (pixel_color),
		.row_end            (row_end),
		.frame_end          (frame_end),
		.mismatch_count     (mismatch_count),
		.pixels_outstanding (pixels_outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// output side: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (!arst_n) begin
			dst_ready <= 1'b0;
		end else if (holds_done != hold_requests) begin
			dst_ready <= 1'b0;
			repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			holds_done <= holds_done + 1;
		end else begin
			dst_ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_word(input logic act, input logic fs, input logic [7:0] idx,
			input logic [7:0] slot, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		action       <= act;
		frame_start  <= fs;
		pixel_index  <= idx;
		palette_slot <= slot;
		red          <= r;
		green        <= g;
		blue         <= b;
		src_valid    <= 1'b1;
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic fs, input logic [7:0] idx);
		send_word(1'b0, fs, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic load_entry(input logic [7:0] slot, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		send_word(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)), slot, r, g, b);
	endtask

	// drain the block before touching the registers
	task automatic settle();
		src_valid <= 1'b0;
		@(negedge clk);
		while (pixels_outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int unsigned spread(input int unsigned lo, input int unsigned hi,
			input int unsigned mid_hi);
		case ($urandom_range(3))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(mid_hi, lo);
		endcase
	endfunction

	task automatic pick_settings();
		write_reg(REG_SCALE_MODE, $urandom_range(1));
		write_reg(REG_AVERAGE_ENABLE, $urandom_range(1));
		write_reg(REG_BLUE_FIRST, $urandom_range(1));
		write_reg(REG_CROP_LEFT, spread(0, 319, 319));
		write_reg(REG_CROP_WIDTH, spread(1, 320, 320));
		write_reg(REG_CROP_ROWS, spread(1, 200, 3));
	endtask

	// mostly raster runs from a frame start, with palette loads and stray restarts
	task automatic stream_segment(input int unsigned count);
		int unsigned sent;
		int unsigned run_len;
		int unsigned k;
		bit          fresh;
		sent = 0;
		while (sent < count) begin
			run_len = $urandom_range(700, 20);
			fresh   = ($urandom_range(9) < 8);
			for (k = 0; k < run_len && sent < count; k++) begin
				if ($urandom_range(99) < 6)
					load_entry(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
				else
					send_pixel((fresh && k == 0) || $urandom_range(499) == 0,
						8'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: crop window over the whole of row 0 in crop mode
		write_reg(REG_CROP_LEFT, 0);
		write_reg(REG_CROP_WIDTH, 320);
		write_reg(REG_CROP_ROWS, 1);
		send_word(1'b1, 1'b1, 8'hAA, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		send_word(1'b1, 1'b0, 8'h55, 8'd255, 8'h07, 8'h03, 8'hF8);
		load_entry(8'd1, 8'hFF, 8'h00, 8'h00);
		send_pixel(1'b1, 8'd0);
		send_pixel(1'b0, 8'd255);
		send_pixel(1'b0, 8'd1);
		send_pixel(1'b0, 8'd2);
		send_pixel(1'b1, 8'd1);
		settle();
		write_reg(REG_BLUE_FIRST, 0);
		load_entry(8'd2, 8'hFF, 8'h80, 8'h01);
		send_pixel(1'b0, 8'd2);
		send_pixel(1'b0, 8'd1);
		settle();
		// drop every fourth column and row
		write_reg(REG_SCALE_MODE, 1);
		write_reg(REG_AVERAGE_ENABLE, 0);
		send_pixel(1'b1, 8'd0);
		send_pixel(1'b0, 8'd255);
		send_pixel(1'b0, 8'd1);
		send_pixel(1'b0, 8'd2);
		send_pixel(1'b0, 8'd0);
		settle();
		write_reg(REG_AVERAGE_ENABLE, 1);
		send_pixel(1'b1, 8'd0);
		send_pixel(1'b0, 8'd1);
		settle();
		// window at the right edge
		write_reg(REG_SCALE_MODE, 0);
		write_reg(REG_CROP_LEFT, 319);
		write_reg(REG_CROP_WIDTH, 1);
		write_reg(REG_CROP_ROWS, 200);
		send_pixel(1'b1, 8'd255);
		settle();

		// random runs over three idling patterns
		for (int p = 0; p < 3; p++) begin
			src_idle_pct = (p == 0) ? 15 : (p == 1) ? 67 : 0;
			dst_idle_pct = (p == 0) ? 67 : (p == 1) ? 15 : 0;
			if (p == 0)
				for (int s = 0; s < 256; s++)
					load_entry(8'(s), 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)));
			for (int s = 0; s < 2; s++) begin
				settle();
				pick_settings();
				if (p == 2 && s == 0)
					hold_requests <= hold_requests + 1;
				stream_segment(SEGMENT_WORDS);
			end
		end
		settle();

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_ram.sv
hw/rtl/pdc_cfg.sv
hw/rtl/pdc_raster.sv
hw/rtl/palette_downscale_compositor.sv
dv/pdc_checker.sv
dv/tb_palette_downscale_compositor.sv
